// File: rtl/assert_macros.svh
// assertion macros for the checker file fcb_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset held off
`define FCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, reset held off
`define FCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/fcb_pkg.sv
// shared types and constants for the free cluster bitmap allocator
// no dependencies; imported by every module of the block
`default_nettype none

package fcb_pkg;

	// field widths fixed by the request and result formats
	localparam int IDX_W = 16;
	localparam int CFG_W = 17;
	localparam int OUT_TDATA_W = 24;

	// default sizing of the bitmap
	localparam int DEF_MAX_CLUSTERS = 65536;
	localparam int DEF_WORD_BITS = 64;

	// cluster count after reset
	localparam logic [CFG_W-1:0] NUM_CLUSTERS_RST = 17'd65536;

	// request kinds
	typedef enum logic [1:0] {
		REQ_FIND   = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_FREE   = 2'd2,
		REQ_OCCUPY = 2'd3
	} req_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MODIFY,
		ST_SCAN,
		ST_SCAN_DONE
	} fsm_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic take;
		logic decode;
		logic modify;
		logic scan_start;
		logic scan_run;
		logic scan_out;
		logic clear_wr;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_last;
		logic req_find;
		logic scan_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/fcb_ram.sv
// generic single write port, single read port ram with registered read
// depends on fcb_pkg for default sizing
`default_nettype none

module fcb_ram
	import fcb_pkg::*;
#(
	parameter int WIDTH = DEF_WORD_BITS,
	parameter int DEPTH = DEF_MAX_CLUSTERS / DEF_WORD_BITS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/fcb_ctrl.sv
// controller state machine: clearing pass, request decode, update and scan
// depends on fcb_pkg for state, command and status types
`default_nettype none

module fcb_ctrl
	import fcb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	input  wire status_t stat,
	output cmd_t         cmd
);

	fsm_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.req_find) begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end else begin
					cmd.decode = 1'b1;
					state_d = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				if (stat.out_free) begin
					cmd.modify = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_SCAN_DONE;
				end
			end
			ST_SCAN_DONE: begin
				if (stat.out_free) begin
					cmd.scan_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/fcb_dpath.sv
// datapath: bound register, index split, bitmap ram, word scan, result register
// depends on fcb_pkg and fcb_ram
`default_nettype none

module fcb_dpath
	import fcb_pkg::*;
#(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	output status_t                     stat,
	input  wire logic [IDX_W-1:0]       s_tdata,
	input  wire logic [1:0]             s_tuser,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   m_tready,
	output logic                        m_tvalid,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int MAP_WORDS = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BI = $clog2(WORD_BITS);
	localparam int BW = ($clog2(MAX_CLUSTERS) + 1 > CFG_W) ? $clog2(MAX_CLUSTERS) + 1 : CFG_W;
	localparam int PW = 2 * IDX_W + 1;
	localparam logic [IDX_W:0] RECIP = (IDX_W + 1)'((2 ** IDX_W) / WORD_BITS);

	// bound register
	logic [CFG_W-1:0] num_q;
	logic [BW-1:0]    num_ext, lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_CLUSTERS_RST;
		end else if (cfg_valid) begin
			num_q <= cfg_data;
		end
	end

	assign num_ext = BW'(num_q);
	assign lim = (num_ext > BW'(MAX_CLUSTERS)) ? BW'(MAX_CLUSTERS) : num_ext;

	// request capture with reciprocal estimate of the word number
	logic [PW-1:0]    prod_in;
	logic [IDX_W-1:0] idx_q, q_est_s1;
	req_t             req_q;

	assign prod_in = PW'(s_tdata) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q <= s_tdata;
			req_q <= req_t'(s_tuser);
			q_est_s1 <= prod_in[2*IDX_W-1:IDX_W];
		end
	end

	// correct the estimate by one compare and subtract
	logic [IDX_W-1:0] prod_back, rem_w, q_fix;
	logic [BI:0]      rem_lo, rem_fix;
	logic             rem_hi, in_range;

	assign prod_back = q_est_s1 * IDX_W'(WORD_BITS);
	assign rem_w = idx_q - prod_back;
	assign rem_lo = rem_w[BI:0];
	assign rem_hi = rem_lo >= (BI + 1)'(WORD_BITS);
	assign q_fix = q_est_s1 + IDX_W'(rem_hi);
	assign rem_fix = rem_hi ? rem_lo - (BI + 1)'(WORD_BITS) : rem_lo;
	assign in_range = BW'(idx_q) < lim;

	logic [AW-1:0] word_addr_q;
	logic [BI-1:0] bit_q;
	logic          in_range_q;

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			word_addr_q <= AW'(q_fix);
			bit_q <= rem_fix[BI-1:0];
			in_range_q <= in_range;
		end
	end

	// clearing pass counter
	logic [AW-1:0] clear_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clear_addr_q <= clear_addr_q + AW'(1);
		end
	end

	// scan issue stage
	logic [AW-1:0]   scan_addr_q;
	logic [BW-1:0]   scan_base_q, base_next, avail_raw;
	logic [BI:0]     avail;
	logic            scan_issue_q, is_last, scan_rd;

	assign base_next = scan_base_q + BW'(WORD_BITS);
	assign is_last = (base_next >= lim) || (scan_addr_q == AW'(MAP_WORDS - 1));
	assign avail_raw = (scan_base_q < lim) ? lim - scan_base_q : '0;
	assign avail = (avail_raw >= BW'(WORD_BITS)) ? (BI + 1)'(WORD_BITS) : avail_raw[BI:0];
	assign scan_rd = cmd.scan_run && scan_issue_q;

	// bitmap memory
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata, bit_mask, new_word;
	logic                 upd;

	assign bit_mask = WORD_BITS'(1) << bit_q;
	assign upd = (req_q == REQ_FREE) || (req_q == REQ_OCCUPY);

	always_comb begin
		unique case (req_q)
			REQ_FREE:   new_word = ram_rdata | bit_mask;
			REQ_OCCUPY: new_word = ram_rdata & ~bit_mask;
			default:    new_word = ram_rdata;
		endcase
	end

	assign ram_we = cmd.clear_wr || (cmd.modify && in_range_q && upd);
	assign ram_waddr = cmd.clear_wr ? clear_addr_q : word_addr_q;
	assign ram_wdata = cmd.clear_wr ? '0 : new_word;
	assign ram_re = cmd.decode || scan_rd;
	assign ram_raddr = cmd.decode ? AW'(q_fix) : scan_addr_q;

	fcb_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// scan data stage: lowest free bit below the bound
	logic                 rd_valid_s1, last_s1;
	logic [BW-1:0]        base_s1;
	logic [BI:0]          avail_s1;
	logic [WORD_BITS-1:0] cand;
	logic [BI-1:0]        hit_bit;
	logic                 hit_any, hit_now;
	logic [BW-1:0]        hit_cluster;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = ram_rdata[b] && ((BI + 1)'(b) < avail_s1);
		end
	end

	always_comb begin
		hit_bit = '0;
		hit_any = 1'b0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit_bit = BI'(b);
				hit_any = 1'b1;
			end
		end
	end

	assign hit_now = rd_valid_s1 && hit_any;
	assign hit_cluster = base_s1 + BW'(hit_bit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_issue_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_issue_q <= 1'b1;
			rd_valid_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_valid_s1 <= scan_issue_q;
			if (scan_issue_q) begin
				scan_issue_q <= !is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_addr_q <= '0;
			scan_base_q <= '0;
		end else if (scan_rd) begin
			scan_addr_q <= scan_addr_q + AW'(1);
			scan_base_q <= base_next;
			base_s1 <= scan_base_q;
			avail_s1 <= avail;
			last_s1 <= is_last;
		end
	end

	// held find result
	logic             hit_q;
	logic [IDX_W-1:0] found_q;

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			hit_q <= 1'b0;
			found_q <= '0;
		end else if (cmd.scan_run && hit_now) begin
			hit_q <= 1'b1;
			found_q <= hit_cluster[IDX_W-1:0];
		end
	end

	// result register
	logic             m_tvalid_q, out_acc_q, out_bit_q;
	logic [IDX_W-1:0] out_found_q;
	logic             out_load;

	assign out_load = cmd.modify || cmd.scan_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.modify) begin
			out_acc_q <= in_range_q;
			out_bit_q <= in_range_q && (req_q == REQ_QUERY) && ram_rdata[bit_q];
			out_found_q <= '0;
		end else if (cmd.scan_out) begin
			out_acc_q <= 1'b1;
			out_bit_q <= hit_q;
			out_found_q <= found_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {(OUT_TDATA_W - IDX_W - 2)'(0), out_found_q, out_bit_q, out_acc_q};

	// status to the controller
	assign stat.clear_last = clear_addr_q == AW'(MAP_WORDS - 1);
	assign stat.req_find = req_q == REQ_FIND;
	assign stat.scan_done = rd_valid_s1 && (hit_any || last_s1);
	assign stat.out_free = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

// File: rtl/free_cluster_bitmap_top.sv
// query, make_free and occupy: input transfer and ram read; make_free and occupy write back,
// with the result loaded once the output side is free; one request at a time
// find_free: examines the bitmap words in order, one word a cycle, until a free bit or the bound
// reset: config returns to 65536 clusters; a clearing pass writes every bitmap
// word to occupied, one word a cycle, with s_tready low
// top level of the free cluster bitmap allocator; depends on fcb_pkg, fcb_ctrl, fcb_dpath
`default_nettype none

module free_cluster_bitmap_top
	import fcb_pkg::*;
#(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IDX_W-1:0]       s_tdata,   // cluster_index[15:0]
	input  wire logic [1:0]             s_tuser,   // req_type[1:0]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // accepted[0], bit_value[1], found_index[17:2]
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	cmd_t    cmd;
	status_t stat;

	// config register always takes a transfer
	assign cfg_ready = 1'b1;

	fcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fcb_dpath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.WORD_BITS    (WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

// File: rtl/fcb_checker.sv
// port-level checks on the free cluster bitmap allocator, bound to the top level
// depends on assert_macros.svh and free_cluster_bitmap_top
`default_nettype none
`include "assert_macros.svh"

module fcb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// one request in flight: no transfer right after another
	`FCB_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a fresh result frees the input side in the same cycle
	`FCB_ASSERT_IMPL(a_result_frees_input, clk, arst_n, $rose(m_tvalid), s_tready)
	// a rejected request reports nothing else
	`FCB_ASSERT_IMPL(a_reject_clean, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[23:1] == 23'd0)
	// a nonzero index only comes with a found cluster
	`FCB_ASSERT_IMPL(a_index_found, clk, arst_n, m_tvalid && (m_tdata[17:2] != 16'd0), m_tdata[1])
	// stalled result holds
	`FCB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind free_cluster_bitmap_top fcb_checker u_fcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

`default_nettype wire
